>>> rtl/rdvd_pkg.sv
// rdvd_pkg: shared types and codes of the radial dent vertex deformer
// used by the dent cell and the top level
package rdvd_pkg;

  localparam int WORD_W = 32;
  localparam int RAD_W  = 31;
  localparam int AXES   = 3;

  // request modes
  typedef enum logic [1:0] {
    MODE_CLEAR  = 2'd0,
    MODE_APPEND = 2'd1,
    MODE_DEFORM = 2'd2,
    MODE_NONE   = 2'd3
  } mode_t;

  // one stored dent, axis 0 in the low word
  typedef struct packed {
    logic [AXES-1:0][WORD_W-1:0] centre;
    logic [AXES-1:0][WORD_W-1:0] push;
    logic [AXES-1:0][WORD_W-1:0] metric;
    logic [RAD_W-1:0]            radius;
  } dent_t;

  // per cell control from the sequencer
  typedef struct packed {
    logic rotate;
    logic load;
  } cell_ctl_t;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DENT,
    ST_MU,
    ST_DCHK,
    ST_DIV,
    ST_SQ,
    ST_T,
    ST_T2,
    ST_W,
    ST_DEL,
    ST_NEXT,
    ST_DONE
  } state_t;

endpackage

>>> rtl/rdvd_if.sv
// rdvd_in_if / rdvd_out_if: valid/ready channels of the dent deformer
// depends on nothing but the fixed field widths
interface rdvd_in_if;
  logic               valid;
  logic               ready;
  logic        [1:0]  mode;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic signed [31:0] point_z;
  logic signed [31:0] push_x;
  logic signed [31:0] push_y;
  logic signed [31:0] push_z;
  logic signed [31:0] metric_x;
  logic signed [31:0] metric_y;
  logic signed [31:0] metric_z;
  logic        [30:0] dent_radius;

  modport source (output valid, mode, point_x, point_y, point_z, push_x, push_y, push_z,
                  metric_x, metric_y, metric_z, dent_radius, input ready);
  modport sink (input valid, mode, point_x, point_y, point_z, push_x, push_y, push_z,
                metric_x, metric_y, metric_z, dent_radius, output ready);
endinterface

interface rdvd_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] out_x;
  logic signed [31:0] out_y;
  logic signed [31:0] out_z;
  logic               status;

  modport source (output valid, out_x, out_y, out_z, status, input ready);
  modport sink (input valid, out_x, out_y, out_z, status, output ready);
endinterface

>>> rtl/rdvd_cell.sv
// rdvd_cell: one slot of the dent ring, loads a new dent or takes its neighbor's
// depends on rdvd_pkg
module rdvd_cell (
  input  logic              clk,
  input  rdvd_pkg::cell_ctl_t ctl,
  input  rdvd_pkg::dent_t   wr_dent,
  input  rdvd_pkg::dent_t   nb_dent,
  output rdvd_pkg::dent_t   dent_q
);

  rdvd_pkg::dent_t dent_r;

  // append write wins over ring rotation
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      dent_r <= wr_dent;
    end else if (ctl.rotate) begin
      dent_r <= nb_dent;
    end
  end

  assign dent_q = dent_r;

endmodule

>>> rtl/radial_dent_vertex_deform.sv
// radial_dent_vertex_deform: dent ring plus one shared multiply/divide sequencer
// depends on rdvd_pkg, rdvd_if.sv (rdvd_in_if, rdvd_out_if) and rdvd_cell
//
//  channel | dir | payload                                   | request taken when
//  in_ch   | in  | mode, point/push/metric xyz, dent_radius  | valid && ready
//  out_ch  | out | out_x/y/z, status                         | valid && ready
//
// clear, append and unused mode: result in the output register in the cycle after the request is taken.
// deform: every ring slot passes the head once; an unused or zero radius slot is skipped,
// a dent out of range after the quotient check is dropped, and an applied dent is the longest
// case (the FRAC_BITS-step restoring divide dominates).
// synchronous active-low reset clears the count and control; dent slots hold until written.
// a stalled result holds the next request off only until the output register frees.
module radial_dent_vertex_deform #(
  parameter int MAX_DENTS = 32,
  parameter int FRAC_BITS = 16
) (
  input logic        clk,
  input logic        rst_n,
  rdvd_in_if.sink    in_ch,
  rdvd_out_if.source out_ch
);

  localparam int CNT_W = $clog2(MAX_DENTS + 1);
  localparam int REM_W = rdvd_pkg::RAD_W + FRAC_BITS;
  localparam int QW    = FRAC_BITS;
  localparam int QS_W  = FRAC_BITS + 1;
  localparam int ACC_W = 2 * FRAC_BITS + 2;
  localparam int T_W   = FRAC_BITS + 1;
  localparam int K_W   = FRAC_BITS + 2;
  localparam int W_W   = FRAC_BITS + 2;
  localparam int MA_W  = 33;
  localparam int PR_W  = 2 * MA_W;
  localparam int BIT_W = $clog2(FRAC_BITS);

  localparam logic [T_W-1:0] ONE_T  = T_W'(1) << FRAC_BITS;
  localparam logic [K_W-1:0] THREE_K = K_W'(3) << FRAC_BITS;

  rdvd_pkg::state_t state_r, state_nxt;

  logic [CNT_W-1:0]  count_r;
  logic [CNT_W-1:0]  k_r;
  logic [1:0]        ax_r;
  logic signed [31:0] pos_r [3];
  logic signed [PR_W-1:0] u_r [3];
  logic              neg_r [3];
  logic [REM_W-1:0]  rem_r [3];
  logic [QW-1:0]     qm_r [3];
  logic [REM_W-1:0]  dsr_r;
  logic [BIT_W-1:0]  bit_r;
  logic [ACC_W-1:0]  acc_r;
  logic [T_W-1:0]    t_r;
  logic [T_W-1:0]    t2_r;
  logic [W_W-1:0]    w_r;
  logic signed [PR_W-1:0] del_r;

  logic               out_valid_r;
  logic signed [31:0] out_x_r, out_y_r, out_z_r;
  logic               status_r;

  logic in_ready, accept, append_go, out_free, head_skip, range_fail;
  rdvd_pkg::dent_t head, wr_dent;
  rdvd_pkg::dent_t cell_q [MAX_DENTS];
  logic signed [MA_W-1:0] mul_a, mul_b;
  logic signed [PR_W-1:0] prod;
  logic [PR_W-1:0]   mag [3];
  logic [PR_W-1:0]   lim;
  logic              ge [3];
  logic signed [QS_W-1:0] q_s [3];
  logic [K_W-1:0]    k3;
  logic signed [PR_W-1:0] sum_del;
  logic signed [31:0] sat_pos;
  logic [1:0]        ax_prev;

  // handshake
  assign out_free  = !out_valid_r || out_ch.ready;
  assign in_ready  = rst_n && (state_r == rdvd_pkg::ST_IDLE) && out_free;
  assign accept    = in_ch.valid && in_ready;
  assign append_go = accept && (in_ch.mode == rdvd_pkg::MODE_APPEND) &&
                     (count_r < CNT_W'(MAX_DENTS));
  assign in_ch.ready = in_ready;

  // dent ring, slot 0 at the head
  assign wr_dent.centre = {in_ch.point_z, in_ch.point_y, in_ch.point_x};
  assign wr_dent.push   = {in_ch.push_z, in_ch.push_y, in_ch.push_x};
  assign wr_dent.metric = {in_ch.metric_z, in_ch.metric_y, in_ch.metric_x};
  assign wr_dent.radius = in_ch.dent_radius;

  for (genvar i = 0; i < MAX_DENTS; i++) begin : g_cell
    localparam int NB = (i + 1) % MAX_DENTS;
    rdvd_pkg::cell_ctl_t ctl;
    assign ctl.rotate = (state_r == rdvd_pkg::ST_NEXT);
    assign ctl.load   = append_go && (count_r == CNT_W'(i));
    rdvd_cell u_cell (
      .clk     (clk),
      .ctl     (ctl),
      .wr_dent (wr_dent),
      .nb_dent (cell_q[NB]),
      .dent_q  (cell_q[i])
    );
  end

  assign head      = cell_q[0];
  assign head_skip = (k_r >= count_r) || (head.radius == '0);

  // quotient range check and divider lanes
  assign lim = PR_W'({head.radius, {FRAC_BITS{1'b0}}});
  always_comb begin
    range_fail = 1'b0;
    for (int a = 0; a < 3; a++) begin
      mag[a] = u_r[a][PR_W-1] ? PR_W'(-u_r[a]) : PR_W'(u_r[a]);
      if (mag[a] >= lim) range_fail = 1'b1;
      ge[a]  = rem_r[a] >= dsr_r;
      q_s[a] = neg_r[a] ? -$signed({1'b0, qm_r[a]}) : $signed({1'b0, qm_r[a]});
    end
  end

  // shared multiplier operands
  assign k3 = THREE_K - {t_r, 1'b0};
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      rdvd_pkg::ST_MU: begin
        if (ax_r != 2'd3) begin
          mul_a = MA_W'(pos_r[ax_r]) - MA_W'($signed(head.centre[ax_r]));
          mul_b = MA_W'($signed(head.metric[ax_r]));
        end
      end
      rdvd_pkg::ST_SQ: begin
        if (ax_r != 2'd3) begin
          mul_a = MA_W'(q_s[ax_r]);
          mul_b = MA_W'(q_s[ax_r]);
        end
      end
      rdvd_pkg::ST_T2: begin
        mul_a = $signed(MA_W'(t_r));
        mul_b = $signed(MA_W'(t_r));
      end
      rdvd_pkg::ST_W: begin
        mul_a = $signed(MA_W'(t2_r));
        mul_b = $signed(MA_W'(k3));
      end
      rdvd_pkg::ST_DEL: begin
        if (ax_r != 2'd3) begin
          mul_a = MA_W'($signed(head.push[ax_r]));
          mul_b = $signed(MA_W'(w_r));
        end
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end
  assign prod = mul_a * mul_b;

  // displacement add with saturation
  assign ax_prev = ax_r - 2'd1;
  assign sum_del = PR_W'(pos_r[ax_prev]) + del_r;
  assign sat_pos = ((&sum_del[PR_W-1:31]) || !(|sum_del[PR_W-1:31])) ? sum_del[31:0] :
                   (sum_del[PR_W-1] ? 32'sh80000000 : 32'sh7fffffff);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rdvd_pkg::ST_IDLE:
        if (accept && in_ch.mode == rdvd_pkg::MODE_DEFORM) state_nxt = rdvd_pkg::ST_DENT;
      rdvd_pkg::ST_DENT:
        if (k_r == CNT_W'(MAX_DENTS)) state_nxt = rdvd_pkg::ST_DONE;
        else if (head_skip)           state_nxt = rdvd_pkg::ST_NEXT;
        else                          state_nxt = rdvd_pkg::ST_MU;
      rdvd_pkg::ST_MU:
        if (ax_r == 2'd2) state_nxt = rdvd_pkg::ST_DCHK;
      rdvd_pkg::ST_DCHK:
        state_nxt = range_fail ? rdvd_pkg::ST_NEXT : rdvd_pkg::ST_DIV;
      rdvd_pkg::ST_DIV:
        if (bit_r == '0) state_nxt = rdvd_pkg::ST_SQ;
      rdvd_pkg::ST_SQ:
        if (ax_r == 2'd2) state_nxt = rdvd_pkg::ST_T;
      rdvd_pkg::ST_T:
        state_nxt = (acc_r[ACC_W-1:FRAC_BITS] >= (ACC_W-FRAC_BITS)'(ONE_T)) ?
                    rdvd_pkg::ST_NEXT : rdvd_pkg::ST_T2;
      rdvd_pkg::ST_T2:  state_nxt = rdvd_pkg::ST_W;
      rdvd_pkg::ST_W:   state_nxt = rdvd_pkg::ST_DEL;
      rdvd_pkg::ST_DEL:
        if (ax_r == 2'd3) state_nxt = rdvd_pkg::ST_NEXT;
      rdvd_pkg::ST_NEXT: state_nxt = rdvd_pkg::ST_DENT;
      rdvd_pkg::ST_DONE:
        if (out_free) state_nxt = rdvd_pkg::ST_IDLE;
      default: state_nxt = rdvd_pkg::ST_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rdvd_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // control registers and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        out_valid_r <= (in_ch.mode != rdvd_pkg::MODE_DEFORM);
        if (in_ch.mode == rdvd_pkg::MODE_CLEAR) count_r <= '0;
        if (append_go) count_r <= count_r + 1'b1;
      end else if (state_r == rdvd_pkg::ST_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      out_x_r  <= '0;
      out_y_r  <= '0;
      out_z_r  <= '0;
      status_r <= (in_ch.mode == rdvd_pkg::MODE_APPEND) && !append_go;
    end else if (state_r == rdvd_pkg::ST_DONE && out_free) begin
      out_x_r  <= pos_r[0];
      out_y_r  <= pos_r[1];
      out_z_r  <= pos_r[2];
      status_r <= 1'b0;
    end
  end

  // walk datapath
  always_ff @(posedge clk) begin
    case (state_r)
      rdvd_pkg::ST_IDLE: begin
        k_r <= '0;
        if (accept) begin
          pos_r[0] <= in_ch.point_x;
          pos_r[1] <= in_ch.point_y;
          pos_r[2] <= in_ch.point_z;
        end
      end
      rdvd_pkg::ST_DENT: ax_r <= 2'd0;
      rdvd_pkg::ST_MU: begin
        if (ax_r != 2'd3) u_r[ax_r] <= prod;
        ax_r <= ax_r + 2'd1;
      end
      rdvd_pkg::ST_DCHK: begin
        for (int a = 0; a < 3; a++) begin
          rem_r[a] <= mag[a][REM_W-1:0];
          neg_r[a] <= u_r[a][PR_W-1];
          qm_r[a]  <= '0;
        end
        dsr_r <= REM_W'({head.radius, {(FRAC_BITS-1){1'b0}}});
        bit_r <= BIT_W'(FRAC_BITS - 1);
        acc_r <= '0;
        ax_r  <= 2'd0;
      end
      rdvd_pkg::ST_DIV: begin
        for (int a = 0; a < 3; a++) begin
          if (ge[a]) rem_r[a] <= rem_r[a] - dsr_r;
          qm_r[a] <= {qm_r[a][QW-2:0], ge[a]};
        end
        dsr_r <= dsr_r >> 1;
        bit_r <= bit_r - 1'b1;
      end
      rdvd_pkg::ST_SQ: begin
        acc_r <= acc_r + prod[ACC_W-1:0];
        ax_r  <= ax_r + 2'd1;
      end
      rdvd_pkg::ST_T: t_r <= ONE_T - acc_r[FRAC_BITS+T_W-1:FRAC_BITS];
      rdvd_pkg::ST_T2: t2_r <= prod[FRAC_BITS+T_W-1:FRAC_BITS];
      rdvd_pkg::ST_W: begin
        w_r  <= prod[FRAC_BITS+W_W-1:FRAC_BITS];
        ax_r <= 2'd0;
      end
      rdvd_pkg::ST_DEL: begin
        // multiply one axis while the previous axis is added
        if (ax_r != 2'd3) del_r <= prod >>> FRAC_BITS;
        if (ax_r != 2'd0) pos_r[ax_prev] <= sat_pos;
        ax_r <= ax_r + 2'd1;
      end
      rdvd_pkg::ST_NEXT: k_r <= k_r + 1'b1;
      default: begin
      end
    endcase
  end

  assign out_ch.valid  = out_valid_r;
  assign out_ch.out_x  = out_x_r;
  assign out_ch.out_y  = out_y_r;
  assign out_ch.out_z  = out_z_r;
  assign out_ch.status = status_r;

  // count never passes the ring size
  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_DENTS))
    else $error("dent count above ring size");

  // a finished walk has turned the ring exactly once
  a_ring_home: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == rdvd_pkg::ST_DONE |-> k_r == CNT_W'(MAX_DENTS))
    else $error("walk ended off ring home position");

  // refused append leaves the count alone
  a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_ch.mode == rdvd_pkg::MODE_APPEND && count_r == CNT_W'(MAX_DENTS)
    |=> $stable(count_r))
    else $error("refused append changed count");

  // restoring divide keeps remainder below twice the divisor
  a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == rdvd_pkg::ST_DIV |-> {1'b0, rem_r[0]} < {dsr_r, 1'b0})
    else $error("divider remainder out of range");

  // ring never turns past one revolution in a walk
  a_rot_walk: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == rdvd_pkg::ST_NEXT |-> k_r < CNT_W'(MAX_DENTS))
    else $error("ring turned past one revolution");

endmodule

>>> sim/tb_chan_if.sv
// tb_chan_if: note file for the channel interfaces used by the testbench
// the interfaces themselves come from rtl/rdvd_if.sv; this file holds a small shared package
package tb_dent_pkg;
  localparam int TB_MAX_DENTS = 32;
  localparam int TB_FRAC = 16;
endpackage

>>> sim/tb.sv
// tb: randomized check of radial_dent_vertex_deform against an in-bench dent predictor
// depends on rdvd_pkg, rdvd_if.sv, tb_dent_pkg and the top-level RTL
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    rdvd_pkg::mode_t    mode;
    logic signed [31:0] pt [3];
    logic signed [31:0] push [3];
    logic signed [31:0] metric [3];
    logic [30:0]      radius;
  } req_t;

  typedef struct {
    logic signed [31:0] pos [3];
    logic               status;
  } res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  rdvd_in_if in_ch();
  rdvd_out_if out_ch();

  radial_dent_vertex_deform dut (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  req_t pending_q[$];
  res_t expected_q[$];
  int   errors = 0;
  bit   stim_done = 0;
  int   idle_cycles = 0;
  int   hold_off = 0;
  int   in_gap = 0;
  int   out_gap = 0;

  // predictor state for the dent table
  int unsigned dents_held = 0;
  longint      d_centre [tb_dent_pkg::TB_MAX_DENTS][3];
  longint      d_push   [tb_dent_pkg::TB_MAX_DENTS][3];
  longint      d_metric [tb_dent_pkg::TB_MAX_DENTS][3];
  longint      d_radius [tb_dent_pkg::TB_MAX_DENTS];

  function automatic longint floor_frac(longint v);
    return v >>> tb_dent_pkg::TB_FRAC;
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // one dent's smoothstep displacement on the running position
  function automatic void dent_push(int k, ref longint pos[3]);
    longint q[3];
    longint one;
    longint unsigned sum, s, t, t2, w;
    one = longint'(1) << tb_dent_pkg::TB_FRAC;
    sum = 0;
    if (d_radius[k] <= 0) return;
    for (int a = 0; a < 3; a++) begin
      q[a] = ((pos[a] - d_centre[k][a]) * d_metric[k][a]) / d_radius[k];
      if (q[a] >= one || q[a] <= -one) return;
    end
    for (int a = 0; a < 3; a++) sum += longint'(q[a] * q[a]);
    s = sum >> tb_dent_pkg::TB_FRAC;
    if (s >= one) return;
    t = one - s;
    t2 = (t * t) >> tb_dent_pkg::TB_FRAC;
    w = (t2 * (3 * one - 2 * t)) >> tb_dent_pkg::TB_FRAC;
    for (int a = 0; a < 3; a++)
      pos[a] = clamp32(pos[a] + floor_frac(d_push[k][a] * longint'(w)));
  endfunction

  function automatic res_t deform_predict(req_t r);
    res_t   o;
    longint pos[3];
    o.status = 1'b0;
    for (int a = 0; a < 3; a++) o.pos[a] = '0;
    case (r.mode)
      rdvd_pkg::MODE_CLEAR: dents_held = 0;
      rdvd_pkg::MODE_APPEND: begin
        if (dents_held >= tb_dent_pkg::TB_MAX_DENTS) o.status = 1'b1;
        else begin
          for (int a = 0; a < 3; a++) begin
            d_centre[dents_held][a] = r.pt[a];
            d_push[dents_held][a] = r.push[a];
            d_metric[dents_held][a] = r.metric[a];
          end
          d_radius[dents_held] = longint'({1'b0, r.radius});
          dents_held++;
        end
      end
      rdvd_pkg::MODE_DEFORM: begin
        for (int a = 0; a < 3; a++) pos[a] = r.pt[a];
        for (int k = 0; k < dents_held; k++) dent_push(k, pos);
        for (int a = 0; a < 3; a++) o.pos[a] = pos[a][31:0];
      end
      default: ;
    endcase
    return o;
  endfunction

  function automatic logic signed [31:0] rnd_word();
    case ($urandom_range(0, 5))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return $urandom_range(0, 1) ? 32'sd0 : -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  // small values near a dent centre so vertices land inside the falloff
  function automatic logic signed [31:0] near(logic signed [31:0] c, int span);
    return c + $signed($urandom_range(0, 2 * span)) - span;
  endfunction

  function automatic req_t mk_dent(logic signed [31:0] c, bit wild);
    req_t r;
    r.mode = rdvd_pkg::MODE_APPEND;
    for (int a = 0; a < 3; a++) begin
      r.pt[a] = wild ? rnd_word() : near(c, 32'h40000);
      r.push[a] = wild ? rnd_word() : $signed($urandom_range(0, 32'h80000)) - 32'h40000;
      r.metric[a] = wild ? rnd_word() :
                    ($urandom_range(0, 7) == 0 ? 32'sd0 : $signed($urandom_range(1, 32'h30000)));
    end
    r.radius = wild ? 31'($urandom) : 31'($urandom_range(1, 32'h80000));
    // now and then a zero radius dent, which must leave vertices alone
    if (wild && $urandom_range(0, 15) == 0) r.radius = '0;
    return r;
  endfunction

  function automatic req_t mk_vertex(logic signed [31:0] c, bit wild);
    req_t r;
    r = mk_dent(c, 1'b1);
    r.mode = rdvd_pkg::MODE_DEFORM;
    for (int a = 0; a < 3; a++) r.pt[a] = wild ? rnd_word() : near(c, 32'h60000);
    return r;
  endfunction

  function automatic req_t mk_mode(rdvd_pkg::mode_t m);
    req_t r;
    r = mk_dent(32'sd0, 1'b1);
    r.mode = m;
    return r;
  endfunction

  // stimulus: directed corners, then random dent sets with vertices nearby
  initial begin
    req_t r;
    logic signed [31:0] ctr;
    int n_dents;
    r = mk_mode(rdvd_pkg::MODE_DEFORM);
    pending_q = {pending_q, r};
    r = mk_dent(32'sd0, 1'b0);
    pending_q = {pending_q, r};
    r = mk_vertex(32'sd0, 1'b0);
    for (int a = 0; a < 3; a++) r.pt[a] = 32'sd0;
    pending_q = {pending_q, r};
    // extreme dent: max push, most negative metric, max radius, at the range edges
    r = mk_dent(32'sd0, 1'b0);
    for (int a = 0; a < 3; a++) begin
      r.pt[a] = 32'sh7fffffff; r.push[a] = 32'sh7fffffff; r.metric[a] = 32'sh80000000;
    end
    r.radius = 31'h7fffffff;
    pending_q = {pending_q, r};
    r = mk_vertex(32'sh7fffffff, 1'b0);
    for (int a = 0; a < 3; a++) r.pt[a] = 32'sh7fffffff;
    pending_q = {pending_q, r};
    r = mk_mode(rdvd_pkg::MODE_NONE);
    pending_q = {pending_q, r};
    // fill the table to overflow
    for (int i = 0; i < 32; i++) pending_q = {pending_q, mk_dent(32'sd0, 1'b0)};
    pending_q = {pending_q, mk_dent(32'sd0, 1'b0)};
    pending_q = {pending_q, mk_vertex(32'sd0, 1'b0)};
    pending_q = {pending_q, mk_mode(rdvd_pkg::MODE_CLEAR)};
    pending_q = {pending_q, mk_vertex(32'sd0, 1'b1)};
    while (pending_q.size() < 790) begin
      ctr = $urandom_range(0, 3) == 0 ? rnd_word() : $signed($urandom_range(0, 32'h200000));
      n_dents = $urandom_range(0, 9) == 0 ? 34 : $urandom_range(1, 4);
      pending_q = {pending_q, mk_mode($urandom_range(0, 9) == 0 ? rdvd_pkg::MODE_NONE :
                                                                  rdvd_pkg::MODE_CLEAR)};
      for (int i = 0; i < n_dents; i++)
        pending_q = {pending_q, mk_dent(ctr, $urandom_range(0, 5) == 0)};
      for (int i = 0; i < $urandom_range(2, 8); i++)
        pending_q = {pending_q, mk_vertex(ctr, $urandom_range(0, 5) == 0)};
    end
    stim_done = 1;
  end

  // reset at the start of the run
  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
  end

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.mode <= '0;
      in_ch.point_x <= '0; in_ch.point_y <= '0; in_ch.point_z <= '0;
      in_ch.push_x <= '0; in_ch.push_y <= '0; in_ch.push_z <= '0;
      in_ch.metric_x <= '0; in_ch.metric_y <= '0; in_ch.metric_z <= '0;
      in_ch.dent_radius <= '0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        expected_q = {expected_q, deform_predict(pending_q.pop_front())};
        in_gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) :
                 ($urandom_range(0, 1) ? 0 : $urandom_range(1, 3));
      end
      if (in_gap > 0 && !(in_ch.valid && !in_ch.ready)) begin
        in_gap--;
        in_ch.valid <= 1'b0;
      end else if (pending_q.size() > 0) begin
        in_ch.valid <= 1'b1;
        in_ch.mode <= pending_q[0].mode;
        in_ch.point_x <= pending_q[0].pt[0];
        in_ch.point_y <= pending_q[0].pt[1];
        in_ch.point_z <= pending_q[0].pt[2];
        in_ch.push_x <= pending_q[0].push[0];
        in_ch.push_y <= pending_q[0].push[1];
        in_ch.push_z <= pending_q[0].push[2];
        in_ch.metric_x <= pending_q[0].metric[0];
        in_ch.metric_y <= pending_q[0].metric[1];
        in_ch.metric_z <= pending_q[0].metric[2];
        in_ch.dent_radius <= pending_q[0].radius;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // result monitor with random stalls and one long hold-off
  always @(posedge clk) begin
    res_t e;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      hold_off = 400;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result x=%0d y=%0d z=%0d status=%0b", $realtime,
                   out_ch.out_x, out_ch.out_y, out_ch.out_z, out_ch.status);
          errors++;
        end else begin
          e = expected_q.pop_front();
          if (out_ch.out_x !== e.pos[0] || out_ch.out_y !== e.pos[1] ||
              out_ch.out_z !== e.pos[2] || out_ch.status !== e.status) begin
            $display("%0t: mismatch expected x=%0d y=%0d z=%0d status=%0b", $realtime,
                     e.pos[0], e.pos[1], e.pos[2], e.status);
            $display("%0t:          actual   x=%0d y=%0d z=%0d status=%0b", $realtime,
                     out_ch.out_x, out_ch.out_y, out_ch.out_z, out_ch.status);
            errors++;
          end
        end
        out_gap = ($urandom_range(0, 11) == 0) ? $urandom_range(10, 80) :
                  ($urandom_range(0, 1) ? 0 : $urandom_range(1, 4));
      end
      if (hold_off > 0 && pending_q.size() < 700) begin
        hold_off--;
        out_ch.ready <= 1'b0;
      end else if (out_gap > 0) begin
        out_gap--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // watchdog on cycles with no request moving
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !rst_n)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 5000) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  // end of run
  initial begin
    wait (stim_done);
    @(posedge clk);
    wait (pending_q.size() == 0 && expected_q.size() == 0);
    repeat (50) @(posedge clk);
    if (errors == 0) $display("tb: done, clean");
    else $display("tb: done, errors");
    $finish;
  end
endmodule
